// ----- hdl/lcc_pkg.sv -----
`default_nettype none

package lcc_pkg;

    localparam int SLOTS_DEF      = 4;
    localparam int OWNER_BITS_DEF = 8;
    localparam int CHUNK_W        = 16;
    localparam int SLOT_IO_W      = 2;
    localparam int STAMP_W        = 32;

    typedef enum logic [1:0] {
        MODE_LOOKUP  = 2'd0,
        MODE_RESERVE = 2'd1,
        MODE_PUBLISH = 2'd2,
        MODE_RELEASE = 2'd3
    } lcc_mode_t;

    // per-slot decisions from the shared compare unit
    typedef struct packed {
        logic hit;
        logic empty;
        logic older;
        logic owner_match;
    } lcc_eval_t;

endpackage

`default_nettype wire

// ----- hdl/lcc_slot_eval.sv -----
`default_nettype none

module lcc_slot_eval
    import lcc_pkg::*;
#(
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  wire logic [OWNER_BITS-1:0] slot_owner,
    input  wire logic [CHUNK_W-1:0]    slot_chunk,
    input  wire logic                  slot_verified,
    input  wire logic [STAMP_W-1:0]    slot_stamp,
    input  wire logic [OWNER_BITS-1:0] req_owner,
    input  wire logic [CHUNK_W-1:0]    req_chunk,
    input  wire logic                  have_pick,
    input  wire logic [STAMP_W-1:0]    best_stamp,
    output lcc_eval_t                  eval
);

    logic owner_eq;

    assign owner_eq          = (slot_owner == req_owner);
    assign eval.owner_match  = owner_eq;
    assign eval.hit          = slot_verified && owner_eq && (slot_chunk == req_chunk);
    assign eval.empty        = (slot_owner == '0);
    assign eval.older        = slot_verified && (!have_pick || (slot_stamp < best_stamp));

endmodule

`default_nettype wire

// ----- hdl/lru_chunk_cache_with_pinning.sv -----
// Start is taken in idle; publish and owner zero go straight to the finish
// state, other modes scan the slots first (one slot compared per cycle); then
// done pulses. One transaction at a time: busy stays high until the result cycle,
// in which the next start is taken.
// Results cannot be stalled. rst_n is asynchronous, active low: all slots empty.
`default_nettype none

module lru_chunk_cache_with_pinning
    import lcc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            mode,
    input  wire logic [OWNER_BITS-1:0] owner_id,
    input  wire logic [CHUNK_W-1:0]    chunk_index,
    input  wire logic [SLOT_IO_W-1:0]  slot_index,
    output logic                       done,
    output logic                       ok,
    output logic [SLOT_IO_W-1:0]       slot_out
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PUB_W  = (SLOT_W > SLOT_IO_W) ? SLOT_W : SLOT_IO_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    lcc_mode_t               mode_reg;
    logic [OWNER_BITS-1:0]   owner_reg;
    logic [CHUNK_W-1:0]      chunk_reg;
    logic [SLOT_IO_W-1:0]    slotsel_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    found_reg;
    logic [SLOT_W-1:0]       pick_reg;
    logic [STAMP_W-1:0]      best_reg;
    logic [STAMP_W-1:0]      use_reg;
    logic                    done_reg;
    logic                    ok_reg;
    logic [SLOT_IO_W-1:0]    slot_out_reg;

    logic [OWNER_BITS-1:0]   slot_owner_reg    [SLOTS];
    logic                    slot_verified_reg [SLOTS];
    logic [CHUNK_W-1:0]      slot_chunk_reg    [SLOTS];
    logic [STAMP_W-1:0]      slot_stamp_reg    [SLOTS];

    logic [SLOT_W-1:0]       cur;
    logic                    last;
    lcc_eval_t               ev;
    logic [STAMP_W-1:0]      use_next;
    logic [PUB_W-1:0]        pub_wide;
    logic [SLOT_W-1:0]       pub_idx;
    logic                    pub_ok;
    logic [PUB_W-1:0]        pick_wide;

    assign cur       = idx_reg[SLOT_W-1:0];
    assign last      = (idx_reg == CNT_W'(SLOTS - 1));
    assign use_next  = use_reg + STAMP_W'(1);
    assign pub_wide  = PUB_W'(slotsel_reg);
    assign pub_idx   = pub_wide[SLOT_W-1:0];
    assign pub_ok    = (int'(pub_wide) < SLOTS) && (slot_owner_reg[pub_idx] != '0);
    assign pick_wide = PUB_W'(pick_reg);

    lcc_slot_eval #(
        .OWNER_BITS (OWNER_BITS)
    ) u_eval (
        .slot_owner    (slot_owner_reg[cur]),
        .slot_chunk    (slot_chunk_reg[cur]),
        .slot_verified (slot_verified_reg[cur]),
        .slot_stamp    (slot_stamp_reg[cur]),
        .req_owner     (owner_reg),
        .req_chunk     (chunk_reg),
        .have_pick     (found_reg),
        .best_stamp    (best_reg),
        .eval          (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_LOOKUP;
            owner_reg    <= '0;
            chunk_reg    <= '0;
            slotsel_reg  <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            pick_reg     <= '0;
            best_reg     <= '0;
            use_reg      <= '0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            slot_out_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_owner_reg[i]    <= '0;
                slot_verified_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg    <= lcc_mode_t'(mode);
                        owner_reg   <= owner_id;
                        chunk_reg   <= chunk_index;
                        slotsel_reg <= slot_index;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        pick_reg    <= '0;
                        if ((lcc_mode_t'(mode) == MODE_PUBLISH) || (owner_id == '0))
                            state_reg <= ST_FINISH;
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    case (mode_reg)
                        MODE_LOOKUP:
                        begin
                            if (ev.hit)
                            begin
                                found_reg <= 1'b1;
                                pick_reg  <= cur;
                                state_reg <= ST_FINISH;
                            end
                            else if (last)
                                state_reg <= ST_FINISH;
                        end
                        MODE_RESERVE:
                        begin
                            if (ev.empty)
                            begin
                                found_reg <= 1'b1;
                                pick_reg  <= cur;
                                state_reg <= ST_FINISH;
                            end
                            else
                            begin
                                if (ev.older)
                                begin
                                    found_reg <= 1'b1;
                                    pick_reg  <= cur;
                                    best_reg  <= slot_stamp_reg[cur];
                                end
                                if (last)
                                    state_reg <= ST_FINISH;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (ev.owner_match)
                            begin
                                slot_owner_reg[cur]    <= '0;
                                slot_verified_reg[cur] <= 1'b0;
                            end
                            if (last)
                                state_reg <= ST_FINISH;
                        end
                        default:
                            state_reg <= ST_FINISH;
                    endcase
                end
                ST_FINISH:
                begin
                    done_reg     <= 1'b1;
                    ok_reg       <= 1'b0;
                    slot_out_reg <= '0;
                    state_reg    <= ST_IDLE;
                    case (mode_reg)
                        MODE_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                use_reg      <= use_next;
                                ok_reg       <= 1'b1;
                                slot_out_reg <= pick_wide[SLOT_IO_W-1:0];
                            end
                        end
                        MODE_RESERVE:
                        begin
                            if (found_reg)
                            begin
                                slot_owner_reg[pick_reg]    <= owner_reg;
                                slot_verified_reg[pick_reg] <= 1'b0;
                                use_reg                     <= use_next;
                                ok_reg                      <= 1'b1;
                                slot_out_reg                <= pick_wide[SLOT_IO_W-1:0];
                            end
                        end
                        MODE_PUBLISH:
                        begin
                            if (pub_ok)
                            begin
                                slot_verified_reg[pub_idx] <= 1'b1;
                                ok_reg                     <= 1'b1;
                            end
                        end
                        default:
                            ok_reg <= 1'b1;
                    endcase
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // slot payload, no reset needed: only read once written by a reserve
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && found_reg)
        begin
            if ((mode_reg == MODE_LOOKUP) || (mode_reg == MODE_RESERVE))
                slot_stamp_reg[pick_reg] <= use_next;
            if (mode_reg == MODE_RESERVE)
                slot_chunk_reg[pick_reg] <= chunk_reg;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign ok       = ok_reg;
    assign slot_out = slot_out_reg;

endmodule

`default_nettype wire

// ----- hdl/lcc_checker.sv -----
`default_nettype none

module lcc_checker
    import lcc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [1:0]           mode,
    input  wire logic                 done,
    input  wire logic                 ok,
    input  wire logic [SLOT_IO_W-1:0] slot_out
);

    // result only closes a transaction that was in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (slot_out == '0))
        else $error("failed transaction reported a nonzero slot");

    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_RELEASE)) ##1 (!busy) |-> 1'b0)
        else $error("release finished without a scan");

endmodule

bind lru_chunk_cache_with_pinning lcc_checker u_lcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .done     (done),
    .ok       (ok),
    .slot_out (slot_out)
);

`default_nettype wire

// ----- verif/lcc_reply_checker.sv -----
`default_nettype none

module lcc_reply_checker
    import lcc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic [1:0]                mode,
    input  wire logic [OWNER_BITS_DEF-1:0] owner_id,
    input  wire logic [CHUNK_W-1:0]        chunk_index,
    input  wire logic [SLOT_IO_W-1:0]      slot_index,
    input  wire logic                      done,
    input  wire logic                      ok,
    input  wire logic [SLOT_IO_W-1:0]      slot_out,
    output int                             errors,
    output int                             pending,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 ok;
        logic [SLOT_IO_W-1:0] slot;
    } cache_reply_t;

    logic [OWNER_BITS_DEF-1:0] tag_owner [SLOTS_DEF];
    logic [CHUNK_W-1:0]        tag_chunk [SLOTS_DEF];
    logic                      tag_valid [SLOTS_DEF];
    logic [STAMP_W-1:0]        tag_stamp [SLOTS_DEF];
    logic [STAMP_W-1:0]        use_count;

    cache_reply_t expected_replies [$];
    cache_reply_t want;

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    function automatic cache_reply_t predict_access(lcc_mode_t m,
                                                    logic [OWNER_BITS_DEF-1:0] own,
                                                    logic [CHUNK_W-1:0] chk,
                                                    logic [SLOT_IO_W-1:0] sl);
        cache_reply_t r;
        bit found;
        bit stop;
        int pick;
        r     = '0;
        found = 0;
        stop  = 0;
        pick  = 0;
        case (m)
            MODE_LOOKUP:
            begin
                if (own != '0)
                begin
                    for (int i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (!found && tag_valid[i] && tag_owner[i] == own &&
                            tag_chunk[i] == chk)
                        begin
                            found = 1;
                            use_count = use_count + 1'b1;
                            tag_stamp[i] = use_count;
                            r.ok   = 1'b1;
                            r.slot = SLOT_IO_W'(i);
                        end
                    end
                end
            end
            MODE_RESERVE:
            begin
                if (own != '0)
                begin
                    // first empty slot wins, else oldest verified; unverified are pinned
                    for (int i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (!stop)
                        begin
                            if (tag_owner[i] == '0)
                            begin
                                pick  = i;
                                found = 1;
                                stop  = 1;
                            end
                            else if (tag_valid[i] &&
                                     (!found || tag_stamp[i] < tag_stamp[pick]))
                            begin
                                pick  = i;
                                found = 1;
                            end
                        end
                    end
                    if (found)
                    begin
                        tag_owner[pick] = own;
                        tag_chunk[pick] = chk;
                        tag_valid[pick] = 1'b0;
                        use_count = use_count + 1'b1;
                        tag_stamp[pick] = use_count;
                        r.ok   = 1'b1;
                        r.slot = SLOT_IO_W'(pick);
                    end
                end
            end
            MODE_PUBLISH:
            begin
                if (int'(sl) < SLOTS_DEF && tag_owner[sl] != '0)
                begin
                    tag_valid[sl] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                if (own != '0)
                begin
                    for (int i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (tag_owner[i] == own)
                        begin
                            tag_owner[i] = '0;
                            tag_valid[i] = 1'b0;
                        end
                    end
                end
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                tag_owner[i] = '0;
                tag_chunk[i] = '0;
                tag_valid[i] = 1'b0;
                tag_stamp[i] = '0;
            end
            use_count = '0;
            expected_replies.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reply: expected none, actual ok=%0b slot=%0d",
                             $time, ok, slot_out);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    checked++;
                    if (ok !== want.ok)
                    begin
                        errors++;
                        $display("%0t: ok mismatch: expected %0b, actual %0b",
                                 $time, want.ok, ok);
                    end
                    if (slot_out !== want.slot)
                    begin
                        errors++;
                        $display("%0t: slot_out mismatch: expected %0d, actual %0d",
                                 $time, want.slot, slot_out);
                    end
                end
            end
            if (start && !busy)
                expected_replies.push_back(predict_access(lcc_mode_t'(mode), owner_id,
                                                          chunk_index, slot_index));
            pending = expected_replies.size();
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam int RANDOM_TXNS = 1750;
    localparam int CALM_TAIL   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      start       = 1'b0;
    logic [1:0]                mode        = '0;
    logic [OWNER_BITS_DEF-1:0] owner_id    = '0;
    logic [CHUNK_W-1:0]        chunk_index = '0;
    logic [SLOT_IO_W-1:0]      slot_index  = '0;
    logic                      busy;
    logic                      done;
    logic                      ok;
    logic [SLOT_IO_W-1:0]      slot_out;

    int errors;
    int pending;
    int checked;
    int cycles = 0;
    int issued = 0;
    bit calm   = 0;

    logic [OWNER_BITS_DEF-1:0] recent_owner [8];
    logic [CHUNK_W-1:0]        recent_chunk [8];
    int                        recent_wr = 0;

    always #5 clk = ~clk;

    lru_chunk_cache_with_pinning u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .owner_id    (owner_id),
        .chunk_index (chunk_index),
        .slot_index  (slot_index),
        .done        (done),
        .ok          (ok),
        .slot_out    (slot_out)
    );

    lcc_reply_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .owner_id    (owner_id),
        .chunk_index (chunk_index),
        .slot_index  (slot_index),
        .done        (done),
        .ok          (ok),
        .slot_out    (slot_out),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies outstanding", cycles, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a rising edge; returns at the accepting edge, or after the idle gap
    task automatic issue_request(lcc_mode_t m, logic [OWNER_BITS_DEF-1:0] own,
                                 logic [CHUNK_W-1:0] chk, logic [SLOT_IO_W-1:0] sl);
        int gap;
        start       <= 1'b1;
        mode        <= m;
        owner_id    <= own;
        chunk_index <= chk;
        slot_index  <= sl;
        do @(posedge clk); while (busy);
        issued++;
        if (m == MODE_RESERVE)
        begin
            recent_owner[recent_wr] = own;
            recent_chunk[recent_wr] = chk;
            recent_wr = (recent_wr + 1) % 8;
        end
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [OWNER_BITS_DEF-1:0] pick_owner();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return OWNER_BITS_DEF'($urandom_range(1, 5));
        else if (r < 95)
            return '0;
        return OWNER_BITS_DEF'($urandom);
    endfunction

    function automatic logic [CHUNK_W-1:0] pick_chunk();
        if ($urandom_range(0, 99) < 80)
            return CHUNK_W'($urandom_range(0, 7));
        return CHUNK_W'($urandom);
    endfunction

    initial
    begin
        int r;
        int k;
        for (int i = 0; i < 8; i++)
        begin
            recent_owner[i] = 8'd1;
            recent_chunk[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // owner zero and empty-slot corner cases
        issue_request(MODE_LOOKUP,  8'h00, 16'h0000, 2'd0);
        issue_request(MODE_RESERVE, 8'h00, 16'h1234, 2'd0);
        issue_request(MODE_RELEASE, 8'h00, 16'h0000, 2'd0);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd3);
        // pinned until published, then hits
        issue_request(MODE_RESERVE, 8'hFF, 16'hFFFF, 2'd0);
        issue_request(MODE_LOOKUP,  8'hFF, 16'hFFFF, 2'd0);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd0);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd0);
        issue_request(MODE_LOOKUP,  8'hFF, 16'hFFFF, 2'd0);
        // fill, evict the only verified slot, then fail with all pinned
        issue_request(MODE_RESERVE, 8'h01, 16'h0000, 2'd2);
        issue_request(MODE_RESERVE, 8'h02, 16'h5555, 2'd1);
        issue_request(MODE_RESERVE, 8'h03, 16'hAAAA, 2'd0);
        issue_request(MODE_RESERVE, 8'h04, 16'h0001, 2'd0);
        issue_request(MODE_RESERVE, 8'h05, 16'h8000, 2'd0);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd1);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd2);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd3);
        issue_request(MODE_PUBLISH, 8'h00, 16'h0000, 2'd0);
        issue_request(MODE_LOOKUP,  8'h01, 16'h0000, 2'd0);
        issue_request(MODE_LOOKUP,  8'h02, 16'h5555, 2'd0);
        issue_request(MODE_LOOKUP,  8'h02, 16'h5554, 2'd0);
        issue_request(MODE_RESERVE, 8'h06, 16'h0F0F, 2'd0);
        issue_request(MODE_RELEASE, 8'h01, 16'h0000, 2'd0);
        issue_request(MODE_RESERVE, 8'h07, 16'hF0F0, 2'd0);
        issue_request(MODE_RELEASE, 8'hFF, 16'hFFFF, 2'd3);

        for (int n = 0; n < RANDOM_TXNS; n++)
        begin
            if (n >= RANDOM_TXNS - CALM_TAIL)
                calm = 1;
            else if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                issue_request(MODE_RESERVE, pick_owner(), pick_chunk(),
                              SLOT_IO_W'($urandom));
            end
            else if (r < 55)
            begin
                issue_request(MODE_PUBLISH, OWNER_BITS_DEF'($urandom),
                              CHUNK_W'($urandom), SLOT_IO_W'($urandom));
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    k = $urandom_range(0, 7);
                    issue_request(MODE_LOOKUP, recent_owner[k], recent_chunk[k],
                                  SLOT_IO_W'($urandom));
                end
                else
                begin
                    issue_request(MODE_LOOKUP, pick_owner(), pick_chunk(),
                                  SLOT_IO_W'($urandom));
                end
            end
            else if (r < 95)
            begin
                issue_request(MODE_RELEASE, pick_owner(), CHUNK_W'($urandom),
                              SLOT_IO_W'($urandom));
            end
            else
            begin
                issue_request(lcc_mode_t'($urandom_range(0, 3)), OWNER_BITS_DEF'($urandom),
                              CHUNK_W'($urandom), SLOT_IO_W'($urandom));
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (SLOTS_DEF + 10) @(posedge clk);

        $display("Ran %0d lookup/reserve/publish/release transactions, %0d replies checked",
                 issued, checked);
        $display("Covered owner zero, pinned slots, LRU eviction and random traffic");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
